### rtl/core/lfmc_pkg.sv
`default_nettype none

package lfmc_pkg;

  // Widths of the configuration fields and the drive outputs
  localparam int unsigned DUTY_W      = 7;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned TRAVEL_W    = 32;
  localparam int unsigned COMPARE_W   = 16;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned NUM_WHEELS  = 4;

  // duty (at most 100) times period (at most 65535) fits in 23 bits
  localparam int unsigned PROD_W      = 23;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // APB register map: register i at byte address 4*i
  localparam int unsigned APB_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_IDX_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_SLOW_DUTY       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FAST_DUTY       = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TRAVEL_DISTANCE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PWM_PERIOD      = 2'd3;

  localparam logic [DUTY_W-1:0]   SLOW_DUTY_RST = 7'd45;
  localparam logic [DUTY_W-1:0]   FAST_DUTY_RST = 7'd90;
  localparam logic [TRAVEL_W-1:0] TRAVEL_RST    = 32'd5;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd99;

  localparam logic [DUTY_W-1:0]   DUTY_FULL     = 7'd100;

  // floor(x/100) = (x * ceil(2^30/100)) >> 30, exact for every x below 2^23
  localparam int unsigned          DIV100_MUL_W = 24;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 24'd10737419;
  localparam int unsigned          DIV100_SHIFT = 30;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE       = 3'd0,
    MODE_FOLLOW     = 3'd1,
    MODE_TURN_RIGHT = 3'd2,
    MODE_TURN_LEFT  = 3'd3,
    MODE_RETRACE    = 3'd4,
    MODE_FINISH     = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    CMD_STOP       = 3'd0,
    CMD_FORWARD    = 3'd1,
    CMD_BACKWARD   = 3'd2,
    CMD_SPIN_RIGHT = 3'd3,
    CMD_SPIN_LEFT  = 3'd4
  } drive_cmd_e;

  typedef struct packed {
    logic                  left_outer;
    logic                  left_inner;
    logic                  middle;
    logic                  right_inner;
    logic                  right_outer;
    logic                  button;
    // bit 0 front left, 1 front right, 2 back left, 3 back right
    logic [NUM_WHEELS-1:0] tick;
  } in_item_t;

  typedef struct packed {
    mode_e      mode;
    drive_cmd_e drive;
  } step_t;

  typedef struct packed {
    logic [PROD_W-1:0] slow_pulse;
    logic [PROD_W-1:0] slow_inv;
    logic [PROD_W-1:0] fast_pulse;
    logic [PROD_W-1:0] fast_inv;
  } prod_t;

  typedef struct packed {
    logic                 pwm_enable;
    logic [COMPARE_W-1:0] left_compare;
    logic                 left_direction;
    logic [COMPARE_W-1:0] right_compare;
    logic                 right_direction;
  } drive_t;

endpackage

`default_nettype wire

### rtl/core/lfmc_cfg.sv
`default_nettype none

module lfmc_cfg (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lfmc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [lfmc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [lfmc_pkg::APB_DATA_W-1:0]     prdata,
  output logic      [lfmc_pkg::TRAVEL_W-1:0]       travel_o,
  output lfmc_pkg::prod_t                          prod_o
);

  logic [lfmc_pkg::DUTY_W-1:0]    slow_duty_q;
  logic [lfmc_pkg::DUTY_W-1:0]    fast_duty_q;
  logic [lfmc_pkg::TRAVEL_W-1:0]  travel_q;
  logic [lfmc_pkg::PERIOD_W-1:0]  period_q;
  logic [lfmc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  logic [lfmc_pkg::DUTY_W-1:0]    slow_clamp;
  logic [lfmc_pkg::DUTY_W-1:0]    fast_clamp;
  lfmc_pkg::prod_t                prod_d;
  lfmc_pkg::prod_t                prod_q;

  assign reg_idx = paddr[lfmc_pkg::REG_IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_duty_q <= lfmc_pkg::SLOW_DUTY_RST;
      fast_duty_q <= lfmc_pkg::FAST_DUTY_RST;
      travel_q    <= lfmc_pkg::TRAVEL_RST;
      period_q    <= lfmc_pkg::PERIOD_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lfmc_pkg::REG_SLOW_DUTY:       slow_duty_q <= pwdata[lfmc_pkg::DUTY_W-1:0];
        lfmc_pkg::REG_FAST_DUTY:       fast_duty_q <= pwdata[lfmc_pkg::DUTY_W-1:0];
        lfmc_pkg::REG_TRAVEL_DISTANCE: travel_q    <= pwdata[lfmc_pkg::TRAVEL_W-1:0];
        lfmc_pkg::REG_PWM_PERIOD:      period_q    <= pwdata[lfmc_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfmc_pkg::REG_SLOW_DUTY:       prdata = lfmc_pkg::APB_DATA_W'(slow_duty_q);
      lfmc_pkg::REG_FAST_DUTY:       prdata = lfmc_pkg::APB_DATA_W'(fast_duty_q);
      lfmc_pkg::REG_TRAVEL_DISTANCE: prdata = lfmc_pkg::APB_DATA_W'(travel_q);
      lfmc_pkg::REG_PWM_PERIOD:      prdata = lfmc_pkg::APB_DATA_W'(period_q);
      default:                       prdata = '0;
    endcase
  end

  // Duties above 100 percent saturate before scaling.
  assign slow_clamp = (slow_duty_q > lfmc_pkg::DUTY_FULL) ? lfmc_pkg::DUTY_FULL : slow_duty_q;
  assign fast_clamp = (fast_duty_q > lfmc_pkg::DUTY_FULL) ? lfmc_pkg::DUTY_FULL : fast_duty_q;

  always_comb begin
    prod_d.slow_pulse = lfmc_pkg::PROD_W'(slow_clamp) * lfmc_pkg::PROD_W'(period_q);
    prod_d.slow_inv   = lfmc_pkg::PROD_W'(lfmc_pkg::DUTY_FULL - slow_clamp)
                        * lfmc_pkg::PROD_W'(period_q);
    prod_d.fast_pulse = lfmc_pkg::PROD_W'(fast_clamp) * lfmc_pkg::PROD_W'(period_q);
    prod_d.fast_inv   = lfmc_pkg::PROD_W'(lfmc_pkg::DUTY_FULL - fast_clamp)
                        * lfmc_pkg::PROD_W'(period_q);
  end

  // The products are registered from the configuration registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign travel_o = travel_q;
  assign prod_o   = prod_q;

endmodule

`default_nettype wire

### rtl/core/lfmc_fsm.sv
`default_nettype none

module lfmc_fsm #(
  parameter int unsigned COUNT_WIDTH = lfmc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_en_i,
  input  wire lfmc_pkg::in_item_t            item_i,
  input  wire logic [lfmc_pkg::TRAVEL_W-1:0] travel_i,
  output lfmc_pkg::step_t                    step_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > lfmc_pkg::TRAVEL_W) ? COUNT_WIDTH
                                                                    : lfmc_pkg::TRAVEL_W;

  lfmc_pkg::mode_e      mode_q, mode_d;
  lfmc_pkg::drive_cmd_e drv_q, drv_d;
  logic                 pend_q, pend_d;
  logic [COUNT_WIDTH-1:0] cnt_q  [lfmc_pkg::NUM_WHEELS];
  logic [COUNT_WIDTH-1:0] cnt_d  [lfmc_pkg::NUM_WHEELS];
  logic [COUNT_WIDTH-1:0] snap_q [lfmc_pkg::NUM_WHEELS];
  logic [COUNT_WIDTH-1:0] moved  [lfmc_pkg::NUM_WHEELS];
  logic                 travelled;
  logic                 snap;
  logic                 cmd_vld;
  lfmc_pkg::drive_cmd_e cmd;
  logic                 pend_t;
  logic                 all_on;

  always_comb begin
    travelled = 1'b1;
    for (int i = 0; i < lfmc_pkg::NUM_WHEELS; i++) begin
      cnt_d[i] = cnt_q[i] + COUNT_WIDTH'(item_i.tick[i]);
      moved[i] = cnt_d[i] - snap_q[i];
      if (CmpW'(moved[i]) < CmpW'(travel_i)) begin
        travelled = 1'b0;
      end
    end
  end

  assign pend_t = pend_q ^ item_i.button;
  assign all_on = item_i.left_outer && item_i.left_inner && item_i.middle
                  && item_i.right_inner && item_i.right_outer;

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_t;
    cmd_vld = 1'b0;
    cmd     = lfmc_pkg::CMD_STOP;
    snap    = 1'b0;
    case (mode_q)
      lfmc_pkg::MODE_IDLE: begin
        cmd_vld = 1'b1;
        if (pend_t) begin
          pend_d = 1'b0;
          mode_d = lfmc_pkg::MODE_FOLLOW;
        end
      end
      lfmc_pkg::MODE_FOLLOW: begin
        if (item_i.right_inner && !item_i.left_inner) begin
          cmd_vld = 1'b1;
          cmd     = lfmc_pkg::CMD_SPIN_RIGHT;
        end else if (item_i.left_inner && !item_i.right_inner) begin
          cmd_vld = 1'b1;
          cmd     = lfmc_pkg::CMD_SPIN_LEFT;
        end else if (all_on) begin
          // Reaching the finish line swallows a pending press.
          pend_d = 1'b0;
          mode_d = lfmc_pkg::MODE_FINISH;
        end else begin
          cmd_vld = 1'b1;
          cmd     = lfmc_pkg::CMD_FORWARD;
        end
        if (pend_d) begin
          pend_d = 1'b0;
          mode_d = lfmc_pkg::MODE_RETRACE;
        end
      end
      lfmc_pkg::MODE_TURN_RIGHT, lfmc_pkg::MODE_TURN_LEFT: begin
        if (travelled) begin
          if (item_i.middle) begin
            mode_d = lfmc_pkg::MODE_FOLLOW;
          end else begin
            cmd_vld = 1'b1;
            cmd     = (mode_q == lfmc_pkg::MODE_TURN_RIGHT) ? lfmc_pkg::CMD_SPIN_RIGHT
                                                            : lfmc_pkg::CMD_SPIN_LEFT;
          end
        end else begin
          cmd_vld = 1'b1;
          cmd     = lfmc_pkg::CMD_FORWARD;
        end
        if (pend_t) begin
          pend_d = 1'b0;
          mode_d = lfmc_pkg::MODE_IDLE;
        end
      end
      lfmc_pkg::MODE_RETRACE: begin
        if (item_i.right_outer) begin
          snap   = 1'b1;
          mode_d = lfmc_pkg::MODE_TURN_RIGHT;
        end else if (item_i.left_outer) begin
          snap   = 1'b1;
          mode_d = lfmc_pkg::MODE_TURN_LEFT;
        end else if (item_i.right_inner && !item_i.left_inner) begin
          cmd_vld = 1'b1;
          cmd     = lfmc_pkg::CMD_SPIN_LEFT;
        end else if (item_i.left_inner && !item_i.right_inner) begin
          cmd_vld = 1'b1;
          cmd     = lfmc_pkg::CMD_SPIN_RIGHT;
        end else begin
          cmd_vld = 1'b1;
          cmd     = lfmc_pkg::CMD_BACKWARD;
        end
        if (pend_t) begin
          pend_d = 1'b0;
          mode_d = lfmc_pkg::MODE_IDLE;
        end
      end
      lfmc_pkg::MODE_FINISH: begin
        cmd_vld = 1'b1;
        if (pend_t) begin
          pend_d = 1'b0;
          mode_d = lfmc_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase
    // Without a new command the last drive is held.
    drv_d = cmd_vld ? cmd : drv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lfmc_pkg::MODE_IDLE;
      drv_q  <= lfmc_pkg::CMD_STOP;
      pend_q <= 1'b0;
      for (int i = 0; i < lfmc_pkg::NUM_WHEELS; i++) begin
        cnt_q[i]  <= '0;
        snap_q[i] <= '0;
      end
    end else if (step_en_i) begin
      mode_q <= mode_d;
      drv_q  <= drv_d;
      pend_q <= pend_d;
      for (int i = 0; i < lfmc_pkg::NUM_WHEELS; i++) begin
        cnt_q[i] <= cnt_d[i];
        if (snap) begin
          snap_q[i] <= cnt_d[i];
        end
      end
    end
  end

  assign step_o.mode  = mode_d;
  assign step_o.drive = drv_d;

endmodule

`default_nettype wire

### rtl/core/lfmc_drive.sv
`default_nettype none

module lfmc_drive (
  input  wire lfmc_pkg::drive_cmd_e cmd_i,
  input  wire lfmc_pkg::prod_t      prod_i,
  output lfmc_pkg::drive_t          drive_o
);

  localparam int unsigned FullW = lfmc_pkg::PROD_W + lfmc_pkg::DIV100_MUL_W;

  logic [lfmc_pkg::PROD_W-1:0] left_prod;
  logic [lfmc_pkg::PROD_W-1:0] right_prod;
  logic [FullW-1:0]            left_full;
  logic [FullW-1:0]            right_full;
  logic                        run;

  always_comb begin
    run                     = 1'b1;
    left_prod               = '0;
    right_prod              = '0;
    drive_o.left_direction  = 1'b0;
    drive_o.right_direction = 1'b0;
    case (cmd_i)
      lfmc_pkg::CMD_FORWARD: begin
        left_prod               = prod_i.slow_inv;
        right_prod              = prod_i.slow_pulse;
        drive_o.left_direction  = 1'b1;
      end
      lfmc_pkg::CMD_BACKWARD: begin
        left_prod               = prod_i.slow_pulse;
        right_prod              = prod_i.slow_inv;
        drive_o.right_direction = 1'b1;
      end
      lfmc_pkg::CMD_SPIN_RIGHT: begin
        left_prod               = prod_i.fast_inv;
        right_prod              = prod_i.fast_inv;
        drive_o.left_direction  = 1'b1;
        drive_o.right_direction = 1'b1;
      end
      lfmc_pkg::CMD_SPIN_LEFT: begin
        left_prod               = prod_i.fast_pulse;
        right_prod              = prod_i.fast_pulse;
      end
      default: begin
        run = 1'b0;
      end
    endcase
  end

  // Divide by 100 through a reciprocal multiply; a stopped drive selects zero.
  assign left_full  = FullW'(left_prod) * FullW'(lfmc_pkg::DIV100_MUL);
  assign right_full = FullW'(right_prod) * FullW'(lfmc_pkg::DIV100_MUL);

  assign drive_o.pwm_enable    = run;
  assign drive_o.left_compare  = left_full[lfmc_pkg::DIV100_SHIFT +: lfmc_pkg::COMPARE_W];
  assign drive_o.right_compare = right_full[lfmc_pkg::DIV100_SHIFT +: lfmc_pkg::COMPARE_W];

endmodule

`default_nettype wire

### rtl/core/line_follower_mode_controller.sv
// Channel   Direction  Handshake                   Payload
// input     in         in_valid_i / in_ready_o     sensors, button, four encoder ticks
// result    out        out_valid_o / out_ready_i   mode, pwm enable, compares, directions
// config    in         APB psel/penable/pwrite     slow/fast duty, travel distance, period
//
// An item is registered on acceptance and stepped into the result register once that
// register is free or emptied; one item per cycle sustained while out_ready_i is high.
// The mode step and PWM scaling sit between the input and result registers.
// Reset clears mode, press flag, wheel counters, snapshots and drive to their idle values.
// A stalled result holds the input register, which then deasserts in_ready_o.
`default_nettype none

module line_follower_mode_controller #(
  parameter int unsigned COUNT_WIDTH = lfmc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              sense_left_outer_i,
  input  wire logic                              sense_left_inner_i,
  input  wire logic                              sense_middle_i,
  input  wire logic                              sense_right_inner_i,
  input  wire logic                              sense_right_outer_i,
  input  wire logic                              button_press_i,
  input  wire logic                              tick_front_left_i,
  input  wire logic                              tick_front_right_i,
  input  wire logic                              tick_back_left_i,
  input  wire logic                              tick_back_right_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [lfmc_pkg::MODE_W-1:0]            robot_mode_o,
  output logic                                   pwm_enable_o,
  output logic [lfmc_pkg::COMPARE_W-1:0]         left_compare_o,
  output logic                                   left_direction_o,
  output logic [lfmc_pkg::COMPARE_W-1:0]         right_compare_o,
  output logic                                   right_direction_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lfmc_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [lfmc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [lfmc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  lfmc_pkg::in_item_t            in_item_q;
  logic                          in_vld_q;
  logic                          out_vld_q;
  logic                          advance;
  logic                          accept;
  logic [lfmc_pkg::TRAVEL_W-1:0] travel;
  lfmc_pkg::prod_t               prod;
  lfmc_pkg::step_t               step;
  lfmc_pkg::drive_t              drive;
  lfmc_pkg::mode_e               mode_q;
  lfmc_pkg::drive_t              drive_q;

  assign pready = 1'b1;

  lfmc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .travel_o (travel),
    .prod_o   (prod)
  );

  // The input register moves on whenever the result register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q.left_outer  <= sense_left_outer_i;
      in_item_q.left_inner  <= sense_left_inner_i;
      in_item_q.middle      <= sense_middle_i;
      in_item_q.right_inner <= sense_right_inner_i;
      in_item_q.right_outer <= sense_right_outer_i;
      in_item_q.button      <= button_press_i;
      in_item_q.tick        <= {tick_back_right_i, tick_back_left_i,
                                tick_front_right_i, tick_front_left_i};
    end
  end

  lfmc_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_item_q),
    .travel_i  (travel),
    .step_o    (step)
  );

  lfmc_drive u_drive (
    .cmd_i   (step.drive),
    .prod_i  (prod),
    .drive_o (drive)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_q  <= step.mode;
      drive_q <= drive;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign robot_mode_o      = mode_q;
  assign pwm_enable_o      = drive_q.pwm_enable;
  assign left_compare_o    = drive_q.left_compare;
  assign left_direction_o  = drive_q.left_direction;
  assign right_compare_o   = drive_q.right_compare;
  assign right_direction_o = drive_q.right_direction;

`ifndef ASSERT_OFF
  a_stop_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !drive_q.pwm_enable |-> drive_q.left_compare == '0
      && drive_q.right_compare == '0 && !drive_q.left_direction
      && !drive_q.right_direction)
    else $error("stopped drive shows a nonzero compare or direction");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("stepped item did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled while the pipeline had room");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
`default_nettype none

module tb;
  import lfmc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned RANDOM_TICKS   = 170;
  localparam int unsigned NUM_PHASES     = 6;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    drive_t            drive;
  } tick_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  in_item_t cur_item = '0;

  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [MODE_W-1:0]     robot_mode_o;
  logic                  pwm_enable_o;
  logic [COMPARE_W-1:0]  left_compare_o;
  logic                  left_direction_o;
  logic [COMPARE_W-1:0]  right_compare_o;
  logic                  right_direction_o;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  always #10 clk_i = ~clk_i;

  line_follower_mode_controller dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .sense_left_outer_i  (cur_item.left_outer),
    .sense_left_inner_i  (cur_item.left_inner),
    .sense_middle_i      (cur_item.middle),
    .sense_right_inner_i (cur_item.right_inner),
    .sense_right_outer_i (cur_item.right_outer),
    .button_press_i      (cur_item.button),
    .tick_front_left_i   (cur_item.tick[0]),
    .tick_front_right_i  (cur_item.tick[1]),
    .tick_back_left_i    (cur_item.tick[2]),
    .tick_back_right_i   (cur_item.tick[3]),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .robot_mode_o        (robot_mode_o),
    .pwm_enable_o        (pwm_enable_o),
    .left_compare_o      (left_compare_o),
    .left_direction_o    (left_direction_o),
    .right_compare_o     (right_compare_o),
    .right_direction_o   (right_direction_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Controller copy: configuration and state as the block should hold them.
  logic [DUTY_W-1:0]   cfg_slow = SLOW_DUTY_RST;
  logic [DUTY_W-1:0]   cfg_fast = FAST_DUTY_RST;
  logic [TRAVEL_W-1:0] cfg_travel = TRAVEL_RST;
  logic [PERIOD_W-1:0] cfg_period = PERIOD_RST;

  mode_e       cur_mode = MODE_IDLE;
  logic        press_flag = 1'b0;
  logic [31:0] wheel_count [NUM_WHEELS] = '{default: '0};
  logic [31:0] turn_snap [NUM_WHEELS] = '{default: '0};
  drive_cmd_e  held_drive = CMD_STOP;

  in_item_t     queued_ticks [$];
  tick_result_t expected_ticks [$];

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned quiet [2] = '{0, 0};
  int unsigned stall_cycles = 0;

  function automatic logic [COMPARE_W-1:0] compare_of(logic [DUTY_W-1:0] duty, bit invert);
    logic [31:0] d;
    d = (duty > DUTY_FULL) ? 32'd100 : 32'(duty);
    if (invert) d = 32'd100 - d;
    return COMPARE_W'((d * 32'(cfg_period)) / 32'd100);
  endfunction

  task automatic advance_controller(input in_item_t it);
    drive_cmd_e   cmd;
    logic         issue;
    logic         travelled;
    logic [31:0]  moved;
    tick_result_t res;
    if (it.button) press_flag = !press_flag;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (it.tick[i]) wheel_count[i] = wheel_count[i] + 32'd1;
    end
    cmd = CMD_STOP;
    issue = 1'b1;
    case (cur_mode)
      MODE_IDLE: begin
        cmd = CMD_STOP;
        if (press_flag) begin
          press_flag = 1'b0;
          cur_mode = MODE_FOLLOW;
        end
      end
      MODE_FOLLOW: begin
        if (it.right_inner && !it.left_inner) cmd = CMD_SPIN_RIGHT;
        else if (it.left_inner && !it.right_inner) cmd = CMD_SPIN_LEFT;
        else if (it.left_outer && it.left_inner && it.middle && it.right_inner
                 && it.right_outer) begin
          issue = 1'b0;
          press_flag = 1'b0;
          cur_mode = MODE_FINISH;
        end else cmd = CMD_FORWARD;
        if (press_flag) begin
          press_flag = 1'b0;
          cur_mode = MODE_RETRACE;
        end
      end
      MODE_TURN_RIGHT, MODE_TURN_LEFT: begin
        travelled = 1'b1;
        for (int i = 0; i < NUM_WHEELS; i++) begin
          moved = wheel_count[i] - turn_snap[i];
          if (moved < cfg_travel) travelled = 1'b0;
        end
        if (!travelled) cmd = CMD_FORWARD;
        else if (it.middle) begin
          issue = 1'b0;
          cur_mode = MODE_FOLLOW;
        end else if (cur_mode == MODE_TURN_RIGHT) cmd = CMD_SPIN_RIGHT;
        else cmd = CMD_SPIN_LEFT;
        if (press_flag) begin
          press_flag = 1'b0;
          cur_mode = MODE_IDLE;
        end
      end
      MODE_RETRACE: begin
        if (it.right_outer || it.left_outer) begin
          issue = 1'b0;
          turn_snap = wheel_count;
          if (it.right_outer) cur_mode = MODE_TURN_RIGHT;
          else cur_mode = MODE_TURN_LEFT;
        end else if (it.right_inner && !it.left_inner) cmd = CMD_SPIN_LEFT;
        else if (it.left_inner && !it.right_inner) cmd = CMD_SPIN_RIGHT;
        else cmd = CMD_BACKWARD;
        if (press_flag) begin
          press_flag = 1'b0;
          cur_mode = MODE_IDLE;
        end
      end
      MODE_FINISH: begin
        cmd = CMD_STOP;
        if (press_flag) begin
          press_flag = 1'b0;
          cur_mode = MODE_IDLE;
        end
      end
      default: issue = 1'b0;
    endcase
    if (issue) held_drive = cmd;

    res = '0;
    res.mode = cur_mode;
    res.drive.pwm_enable = (held_drive != CMD_STOP);
    case (held_drive)
      CMD_FORWARD: begin
        res.drive.left_compare    = compare_of(cfg_slow, 1'b1);
        res.drive.left_direction  = 1'b1;
        res.drive.right_compare   = compare_of(cfg_slow, 1'b0);
        res.drive.right_direction = 1'b0;
      end
      CMD_BACKWARD: begin
        res.drive.left_compare    = compare_of(cfg_slow, 1'b0);
        res.drive.left_direction  = 1'b0;
        res.drive.right_compare   = compare_of(cfg_slow, 1'b1);
        res.drive.right_direction = 1'b1;
      end
      CMD_SPIN_RIGHT: begin
        res.drive.left_compare    = compare_of(cfg_fast, 1'b1);
        res.drive.left_direction  = 1'b1;
        res.drive.right_compare   = compare_of(cfg_fast, 1'b1);
        res.drive.right_direction = 1'b1;
      end
      CMD_SPIN_LEFT: begin
        res.drive.left_compare    = compare_of(cfg_fast, 1'b0);
        res.drive.left_direction  = 1'b0;
        res.drive.right_compare   = compare_of(cfg_fast, 1'b0);
        res.drive.right_direction = 1'b0;
      end
      default: ;
    endcase
    expected_ticks.push_back(res);
  endtask

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int unsigned next_gap(int side);
    int unsigned r;
    if (quiet[side] != 0) begin
      quiet[side]--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet[side] = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sensor patterns are biased toward the ones that move the mode machine.
  function automatic in_item_t random_tick();
    in_item_t it;
    it = in_item_t'($urandom);
    for (int i = 0; i < NUM_WHEELS; i++) it.tick[i] = ($urandom_range(0, 3) != 0);
    it.button = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0: {it.left_outer, it.left_inner, it.middle, it.right_inner, it.right_outer} = 5'b11111;
      1: {it.left_outer, it.left_inner, it.middle, it.right_inner, it.right_outer} = 5'b00010;
      2: {it.left_outer, it.left_inner, it.middle, it.right_inner, it.right_outer} = 5'b01000;
      3: {it.left_outer, it.right_outer} = 2'b00;
      4: {it.left_outer, it.left_inner, it.right_inner, it.right_outer} = 4'b0000;
      default: ;
    endcase
    return it;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want)
      flag_error($sformatf("result %0d %s: expected %0d, got %0d", checked, name, want, got));
  endtask

  task automatic check_tick();
    tick_result_t want;
    if (expected_ticks.size() == 0) begin
      flag_error($sformatf("result %0d arrived with no item outstanding", checked));
    end else begin
      want = expected_ticks.pop_front();
      check_field("robot_mode", 16'(want.mode), 16'(robot_mode_o));
      check_field("pwm_enable", 16'(want.drive.pwm_enable), 16'(pwm_enable_o));
      check_field("left_compare", want.drive.left_compare, left_compare_o);
      check_field("left_direction", 16'(want.drive.left_direction), 16'(left_direction_o));
      check_field("right_compare", want.drive.right_compare, right_compare_o);
      check_field("right_direction", 16'(want.drive.right_direction), 16'(right_direction_o));
    end
    checked++;
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SLOW_DUTY:       cfg_slow = val[DUTY_W-1:0];
      REG_FAST_DUTY:       cfg_fast = val[DUTY_W-1:0];
      REG_TRAVEL_DISTANCE: cfg_travel = val[TRAVEL_W-1:0];
      REG_PWM_PERIOD:      cfg_period = val[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] slow, input logic [31:0] fast,
                           input logic [31:0] travel, input logic [31:0] period);
    write_reg(REG_SLOW_DUTY, slow);
    write_reg(REG_FAST_DUTY, fast);
    write_reg(REG_TRAVEL_DISTANCE, travel);
    write_reg(REG_PWM_PERIOD, period);
  endtask

  task automatic drain();
    while (queued_ticks.size() != 0 || in_valid_i || expected_ticks.size() != 0)
      @(posedge clk_i);
  endtask

  // Input side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) advance_controller(cur_item);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (queued_ticks.size() != 0) begin
          cur_item <= queued_ticks.pop_front();
          in_valid_i <= 1'b1;
          in_gap = next_gap(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_tick();
      if (out_gap != 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = next_gap(1);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the mode machine at the reset settings. Sensors are listed
    // outer left, inner left, middle, inner right, outer right.
    queued_ticks.push_back({5'b00000, 1'b0, 4'h0});
    queued_ticks.push_back({5'b11111, 1'b0, 4'hF});
    queued_ticks.push_back({5'b00000, 1'b1, 4'h0});
    queued_ticks.push_back({5'b00010, 1'b0, 4'hF});
    queued_ticks.push_back({5'b01000, 1'b0, 4'h0});
    queued_ticks.push_back({5'b01010, 1'b0, 4'h0});
    queued_ticks.push_back({5'b11111, 1'b0, 4'h0});
    queued_ticks.push_back({5'b00000, 1'b0, 4'h0});
    queued_ticks.push_back({5'b00000, 1'b1, 4'h0});
    queued_ticks.push_back({5'b00000, 1'b1, 4'h0});
    queued_ticks.push_back({5'b00100, 1'b1, 4'h0});
    queued_ticks.push_back({5'b00010, 1'b0, 4'h0});
    queued_ticks.push_back({5'b01000, 1'b0, 4'h0});
    queued_ticks.push_back({5'b00100, 1'b0, 4'h0});
    queued_ticks.push_back({5'b10000, 1'b0, 4'hF});
    // The turn drives forward until every wheel has moved the full distance.
    repeat (5) queued_ticks.push_back({5'b00000, 1'b0, 4'hF});
    queued_ticks.push_back({5'b00100, 1'b0, 4'h0});
    queued_ticks.push_back({5'b00000, 1'b1, 4'h0});
    queued_ticks.push_back({5'b00001, 1'b0, 4'h0});
    queued_ticks.push_back({5'b00000, 1'b0, 4'hE});
    queued_ticks.push_back({5'b00000, 1'b1, 4'h0});
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: configure(32'd0, 32'd100, 32'd0, 32'd65535);
        1: configure(32'd100, 32'd0, 32'd3, 32'd0);
        // Duties above full scale saturate; the turn never completes.
        2: configure(32'd127, 32'd101, 32'hFFFF_FFFF, 32'd65535);
        default: configure($urandom, $urandom, $urandom_range(0, 12), $urandom);
      endcase
      repeat (RANDOM_TICKS) queued_ticks.push_back(random_tick());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
